// ----- sv/nnis_pkg.sv -----
// ----------------------------------------------------------------------------
// nnis_pkg
// Shared types and constants of the nearest-neighbor image scaler.
// ----------------------------------------------------------------------------
package nnis_pkg;

    localparam int MAX_WIDTH  = 256;
    localparam int MAX_HEIGHT = 256;

    localparam int COL_W   = $clog2(MAX_WIDTH);
    localparam int ROW_W   = $clog2(MAX_HEIGHT);
    localparam int ADDR_W  = COL_W + ROW_W;
    localparam int DIM_W   = 9;
    localparam int SCALE_W = 12;
    localparam int POS_W   = 12;
    localparam int FRAC_W  = 8;
    localparam int NUM_W   = POS_W + FRAC_W;
    localparam int DCNT_W  = $clog2(NUM_W + 1);
    localparam int IDX_W   = 2;
    localparam int DATA_W  = SCALE_W;
    localparam int DEPTH   = MAX_WIDTH * MAX_HEIGHT;

    localparam logic [IDX_W-1:0] REG_IN_WIDTH  = 2'd0;
    localparam logic [IDX_W-1:0] REG_IN_HEIGHT = 2'd1;
    localparam logic [IDX_W-1:0] REG_SCALE_Q8  = 2'd2;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_pix;

    typedef enum logic {
        K_LOAD,
        K_EMIT
    } t_kind;

    typedef struct packed {
        t_kind kind;
        t_pix  pix;
    } t_cmd;

    typedef struct packed {
        logic [DIM_W-1:0]   eff_w;
        logic [DIM_W-1:0]   eff_h;
        logic [SCALE_W-1:0] scale;
    } t_cfg;

    typedef struct packed {
        t_pix pix;
        logic row_end;
        logic last;
        logic empty_res;
    } t_res;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_START,
        ST_DIV,
        ST_READ,
        ST_RDATA
    } t_state;

endpackage

// ----- sv/nnis_front.sv -----
// ----------------------------------------------------------------------------
// nnis_front
// Accepts input beats, tags each as a load or an emit command and holds
// them in a two-entry queue for the back end.
// ----------------------------------------------------------------------------
module nnis_front
    import nnis_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_push,
    input  logic       i_mode,
    input  t_pix       i_pix,
    output logic       o_full,
    output logic       o_valid,
    output t_cmd       o_cmd,
    input  logic       i_take
);

    t_cmd       r_q [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic       n_wp;
    logic       n_rp;
    logic [1:0] n_cnt;
    logic       push_ok;
    logic       take_ok;
    t_cmd       new_cmd;

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_cmd   = r_q[r_rp];
    assign push_ok = i_push && !o_full;
    assign take_ok = i_take && o_valid;

    always_comb begin
        new_cmd.kind = i_mode ? K_EMIT : K_LOAD;
        new_cmd.pix  = i_pix;
        n_wp  = push_ok ? ~r_wp : r_wp;
        n_rp  = take_ok ? ~r_rp : r_rp;
        n_cnt = r_cnt;
        if (push_ok && !take_ok) begin
            n_cnt = r_cnt + 2'd1;
        end else if (take_ok && !push_ok) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_q[r_wp] <= new_cmd;
        end
    end

endmodule

// ----- sv/nnis_div.sv -----
// ----------------------------------------------------------------------------
// nnis_div
// Restoring divider that produces one quotient bit per cycle.
// ----------------------------------------------------------------------------
module nnis_div
    import nnis_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [NUM_W-1:0]   i_num,
    input  logic [SCALE_W-1:0] i_den,
    output logic               o_busy,
    output logic [NUM_W-1:0]   o_quo
);

    logic [NUM_W-1:0]   r_num;
    logic [SCALE_W-1:0] r_rem;
    logic [SCALE_W-1:0] r_den;
    logic [DCNT_W-1:0]  r_cnt;
    logic               r_busy;
    logic [SCALE_W:0]   trial;
    logic               fits;
    logic [SCALE_W:0]   diff;

    assign o_busy = r_busy;
    assign o_quo  = r_num;
    assign trial  = {r_rem, r_num[NUM_W-1]};
    assign fits   = (trial >= {1'b0, r_den});
    assign diff   = trial - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= DCNT_W'(NUM_W);
        end else if (r_busy) begin
            r_cnt <= r_cnt - DCNT_W'(1);
            if (r_cnt == DCNT_W'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_busy) begin
            r_num <= {r_num[NUM_W-2:0], fits};
            r_rem <= fits ? diff[SCALE_W-1:0] : trial[SCALE_W-1:0];
        end
    end

endmodule

// ----- sv/nnis_back.sv -----
// ----------------------------------------------------------------------------
// nnis_back
// Executes queued commands: writes loaded pixels to the frame store and
// produces output pixels through two coordinate dividers and a store read.
// ----------------------------------------------------------------------------
module nnis_back
    import nnis_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_cfg i_cfg,
    input  logic i_cfg_hit,
    input  logic i_valid,
    input  t_cmd i_cmd,
    output logic o_take,
    output t_res o_res,
    output logic o_res_valid,
    input  logic i_pop
);

    t_state             r_state;
    t_state             n_state;
    logic [COL_W-1:0]   r_load_col;
    logic [COL_W-1:0]   n_load_col;
    logic [ROW_W-1:0]   r_load_row;
    logic [ROW_W-1:0]   n_load_row;
    logic [POS_W-1:0]   r_emit_col;
    logic [POS_W-1:0]   n_emit_col;
    logic [POS_W-1:0]   r_emit_row;
    logic [POS_W-1:0]   n_emit_row;
    logic [POS_W-1:0]   r_ow;
    logic [POS_W-1:0]   r_oh;
    logic               r_res_valid;
    logic               n_res_valid;
    t_res               r_res;
    t_res               n_res;
    t_pix               r_rdata;
    t_pix               mem [DEPTH];

    logic               mem_we;
    logic [ADDR_W-1:0]  mem_waddr;
    logic               mem_re;
    logic [ADDR_W-1:0]  mem_raddr;
    logic               res_we;
    logic               div_start;
    logic [NUM_W-1:0]   num_x;
    logic [NUM_W-1:0]   num_y;
    logic               busy_x;
    logic               busy_y;
    logic [NUM_W-1:0]   quo_x;
    logic [NUM_W-1:0]   quo_y;
    logic [COL_W-1:0]   src_x;
    logic [ROW_W-1:0]   src_y;
    logic [DIM_W+SCALE_W-1:0] prod_w;
    logic [DIM_W+SCALE_W-1:0] prod_h;
    logic               slot_free;
    logic               out_empty;
    logic               ld_wrap;
    logic [COL_W-1:0]   ld_col;
    logic [ROW_W-1:0]   ld_row;
    logic [COL_W:0]     ld_col_nx;
    logic [ROW_W:0]     ld_row_nx;
    logic               em_wrap;
    logic [POS_W-1:0]   em_col;
    logic [POS_W-1:0]   em_row;
    logic               rend;
    logic               fin;
    logic [DIM_W-1:0]   lim_x;
    logic [DIM_W-1:0]   lim_y;

    assign o_res       = r_res;
    assign o_res_valid = r_res_valid;
    assign o_take      = (r_state == ST_IDLE) && i_valid;
    assign slot_free   = !r_res_valid || i_pop;
    assign prod_w      = (DIM_W+SCALE_W)'(i_cfg.eff_w) * (DIM_W+SCALE_W)'(i_cfg.scale);
    assign prod_h      = (DIM_W+SCALE_W)'(i_cfg.eff_h) * (DIM_W+SCALE_W)'(i_cfg.scale);
    assign out_empty   = (i_cfg.scale == '0) || (r_ow == '0) || (r_oh == '0);

    assign ld_wrap   = ({1'b0, r_load_col} >= i_cfg.eff_w)
                    || ({1'b0, r_load_row} >= i_cfg.eff_h);
    assign ld_col    = ld_wrap ? '0 : r_load_col;
    assign ld_row    = ld_wrap ? '0 : r_load_row;
    assign ld_col_nx = {1'b0, ld_col} + (COL_W+1)'(1);
    assign ld_row_nx = {1'b0, ld_row} + (ROW_W+1)'(1);

    assign em_wrap = (r_emit_col >= r_ow) || (r_emit_row >= r_oh);
    assign em_col  = em_wrap ? '0 : r_emit_col;
    assign em_row  = em_wrap ? '0 : r_emit_row;
    assign num_x   = {em_col, {FRAC_W{1'b0}}};
    assign num_y   = {em_row, {FRAC_W{1'b0}}};

    assign rend = ({1'b0, r_emit_col} + (POS_W+1)'(1)) == {1'b0, r_ow};
    assign fin  = rend && (({1'b0, r_emit_row} + (POS_W+1)'(1)) == {1'b0, r_oh});

    assign lim_x = i_cfg.eff_w - DIM_W'(1);
    assign lim_y = i_cfg.eff_h - DIM_W'(1);
    assign src_x = (quo_x >= NUM_W'(i_cfg.eff_w)) ? lim_x[COL_W-1:0] : quo_x[COL_W-1:0];
    assign src_y = (quo_y >= NUM_W'(i_cfg.eff_h)) ? lim_y[ROW_W-1:0] : quo_y[ROW_W-1:0];

    nnis_div u_div_x (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (num_x),
        .i_den   (i_cfg.scale),
        .o_busy  (busy_x),
        .o_quo   (quo_x)
    );

    nnis_div u_div_y (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (num_y),
        .i_den   (i_cfg.scale),
        .o_busy  (busy_y),
        .o_quo   (quo_y)
    );

    always_comb begin
        n_state     = r_state;
        n_load_col  = r_load_col;
        n_load_row  = r_load_row;
        n_emit_col  = r_emit_col;
        n_emit_row  = r_emit_row;
        n_res_valid = r_res_valid && !i_pop;
        n_res       = r_res;
        res_we      = 1'b0;
        mem_we      = 1'b0;
        mem_waddr   = {ld_row, ld_col};
        mem_re      = 1'b0;
        mem_raddr   = {src_y, src_x};
        div_start   = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    if (i_cmd.kind == K_LOAD) begin
                        mem_we = 1'b1;
                        if (ld_col_nx >= i_cfg.eff_w) begin
                            n_load_col = '0;
                            n_load_row = (ld_row_nx >= i_cfg.eff_h) ? '0
                                                                    : ld_row_nx[ROW_W-1:0];
                        end else begin
                            n_load_col = ld_col_nx[COL_W-1:0];
                            n_load_row = ld_row;
                        end
                    end else begin
                        n_state = ST_START;
                    end
                end
            end
            ST_START: begin
                if (out_empty) begin
                    if (slot_free) begin
                        res_we            = 1'b1;
                        n_res.pix         = '0;
                        n_res.row_end     = 1'b0;
                        n_res.last        = 1'b0;
                        n_res.empty_res   = 1'b1;
                        n_state           = ST_IDLE;
                    end
                end else begin
                    n_emit_col = em_col;
                    n_emit_row = em_row;
                    div_start  = 1'b1;
                    n_state    = ST_DIV;
                end
            end
            ST_DIV: begin
                if (!busy_x && !busy_y) begin
                    n_state = ST_READ;
                end
            end
            ST_READ: begin
                mem_re  = 1'b1;
                n_state = ST_RDATA;
            end
            ST_RDATA: begin
                if (slot_free) begin
                    res_we          = 1'b1;
                    n_res.pix       = r_rdata;
                    n_res.row_end   = rend;
                    n_res.last      = fin;
                    n_res.empty_res = 1'b0;
                    if (rend) begin
                        n_emit_col = '0;
                        n_emit_row = fin ? '0 : r_emit_row + POS_W'(1);
                    end else begin
                        n_emit_col = r_emit_col + POS_W'(1);
                    end
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
        if (res_we) begin
            n_res_valid = 1'b1;
        end
        if (i_cfg_hit) begin
            n_load_col = '0;
            n_load_row = '0;
            n_emit_col = '0;
            n_emit_row = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_load_col  <= '0;
            r_load_row  <= '0;
            r_emit_col  <= '0;
            r_emit_row  <= '0;
            r_res_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_load_col  <= n_load_col;
            r_load_row  <= n_load_row;
            r_emit_col  <= n_emit_col;
            r_emit_row  <= n_emit_row;
            r_res_valid <= n_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_we) begin
            r_res <= n_res;
        end
        if (o_take && (i_cmd.kind == K_EMIT)) begin
            r_ow <= prod_w[FRAC_W +: POS_W];
            r_oh <= prod_h[FRAC_W +: POS_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= i_cmd.pix;
        end
        if (mem_re) begin
            r_rdata <= mem[mem_raddr];
        end
    end

endmodule

// ----- sv/nearest_neighbor_image_scaler_core.sv -----
// ----------------------------------------------------------------------------
// nearest_neighbor_image_scaler_core
// Nearest-neighbor scaler for 24-bit RGB images with a 64K-pixel frame store.
// ----------------------------------------------------------------------------
// A load beat (mode 0) writes the next pixel of the input image into the
// frame store in raster order and produces no result; the back end retires
// it straight from its idle state. An emit beat (mode 1) produces the next
// output pixel in raster order through the two 20-step restoring dividers
// that map the output column and row to source coordinates, followed by
// one registered store read. An empty output (zero factor or zero size)
// answers an emit beat with empty_res set. A two-beat input queue and a
// one-beat result register let either side stall without blocking the
// other. The frame store needs no clearing pass; reading a pixel that was
// never loaded returns undefined data. Configuration writes rewind both
// the load and the emit position and are allowed only while the block is
// idle.
module nearest_neighbor_image_scaler_core
    import nnis_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [IDX_W-1:0]  i_cfg_idx,
    input  logic [DATA_W-1:0] i_cfg_data,
    input  logic              push,
    output logic              full,
    input  logic              i_mode,
    input  logic [7:0]        i_blue,
    input  logic [7:0]        i_green,
    input  logic [7:0]        i_red,
    output logic              empty,
    input  logic              pop,
    output logic [7:0]        o_out_blue,
    output logic [7:0]        o_out_green,
    output logic [7:0]        o_out_red,
    output logic              o_row_end,
    output logic              o_last,
    output logic              o_empty_res
);

    logic [DIM_W-1:0]   r_in_width;
    logic [DIM_W-1:0]   r_in_height;
    logic [SCALE_W-1:0] r_scale_q8;
    logic               cfg_hit;
    t_cfg               cfg;
    t_pix               in_pix;
    logic               cmd_valid;
    t_cmd               cmd;
    logic               cmd_take;
    t_res               res;
    logic               res_valid;

    always_comb begin
        cfg_hit = 1'b0;
        case (i_cfg_idx)
            REG_IN_WIDTH:  cfg_hit = i_cfg_we;
            REG_IN_HEIGHT: cfg_hit = i_cfg_we;
            REG_SCALE_Q8:  cfg_hit = i_cfg_we;
            default:       cfg_hit = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_width  <= DIM_W'(MAX_WIDTH);
            r_in_height <= DIM_W'(MAX_HEIGHT);
            r_scale_q8  <= SCALE_W'(256);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_IN_WIDTH:  r_in_width  <= i_cfg_data[DIM_W-1:0];
                REG_IN_HEIGHT: r_in_height <= i_cfg_data[DIM_W-1:0];
                REG_SCALE_Q8:  r_scale_q8  <= i_cfg_data[SCALE_W-1:0];
                default:       r_scale_q8  <= r_scale_q8;
            endcase
        end
    end

    always_comb begin
        if (r_in_width == '0) begin
            cfg.eff_w = DIM_W'(1);
        end else if (r_in_width > DIM_W'(MAX_WIDTH)) begin
            cfg.eff_w = DIM_W'(MAX_WIDTH);
        end else begin
            cfg.eff_w = r_in_width;
        end
        if (r_in_height == '0) begin
            cfg.eff_h = DIM_W'(1);
        end else if (r_in_height > DIM_W'(MAX_HEIGHT)) begin
            cfg.eff_h = DIM_W'(MAX_HEIGHT);
        end else begin
            cfg.eff_h = r_in_height;
        end
        cfg.scale = r_scale_q8;
    end

    assign in_pix.red   = i_red;
    assign in_pix.green = i_green;
    assign in_pix.blue  = i_blue;

    nnis_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_mode  (i_mode),
        .i_pix   (in_pix),
        .o_full  (full),
        .o_valid (cmd_valid),
        .o_cmd   (cmd),
        .i_take  (cmd_take)
    );

    nnis_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_cfg_hit   (cfg_hit),
        .i_valid     (cmd_valid),
        .i_cmd       (cmd),
        .o_take      (cmd_take),
        .o_res       (res),
        .o_res_valid (res_valid),
        .i_pop       (pop)
    );

    assign empty       = !res_valid;
    assign o_out_blue  = res.pix.blue;
    assign o_out_green = res.pix.green;
    assign o_out_red   = res.pix.red;
    assign o_row_end   = res.row_end;
    assign o_last      = res.last;
    assign o_empty_res = res.empty_res;

    // An empty-image result carries no pixel and no position flags.
    a_empty_res_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_empty_res) |-> (o_out_red == 8'd0 && o_out_green == 8'd0
            && o_out_blue == 8'd0 && !o_row_end && !o_last))
        else $error("empty-image result carries pixel data or flags");

    // The final pixel of the image always closes a row.
    a_last_ends_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_last) |-> o_row_end)
        else $error("last pixel without row end");

    // The back end only takes a command that the queue actually holds.
    a_take_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd_take |-> cmd_valid)
        else $error("command taken from an empty queue");

endmodule
